@@ sv/aabb_pct_pkg.sv @@
// ---------------------------------------------------------------------------
// AABB pair collision table: shared definitions
// Table size, field codes and the control/status bundles between the
// controller and the datapath.
// ---------------------------------------------------------------------------
package aabb_pct_pkg;

  localparam int SLOTS  = 8;
  localparam int SLOT_W = $clog2(SLOTS);
  typedef logic [SLOT_W-1:0] slot_t;
  localparam slot_t LAST_SLOT = slot_t'(SLOTS - 1);

  // Input request and result widths
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 16;

  // Notify matrix register
  localparam int MATRIX_W = 36;
  localparam logic [MATRIX_W-1:0] MATRIX_RESET = 36'h18A5AAF00;

  // Request modes (tuser of the input stream)
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_SCAN   = 2'd2;

  // Result kinds (tuser of the output stream)
  localparam logic [1:0] EV_ADD    = 2'd0;
  localparam logic [1:0] EV_REMOVE = 2'd1;
  localparam logic [1:0] EV_PAIR   = 2'd2;
  localparam logic [1:0] EV_DONE   = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic add_go;
    logic rem_go;
    logic scan_start;
    logic issue;
    logic done_go;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
    logic last_pair;
  } stat_t;

endpackage

@@ sv/aabb_pairwise_collision_table.sv @@
// Add and remove: one result, valid the cycle after the request is taken;
// one such request per cycle when the output is not stalled.
// Scan: one pair per cycle over all 28 slot pairs, one compare stage and a
// drain step, then a done result. Output stalls hold the scan.
// No new request is taken before the done result of a scan is issued.
// Reset (rst, synchronous): table empty, notify matrix to its default, idle.
// ---------------------------------------------------------------------------
// AABB pair collision table
// Keeps up to eight rectangles, answers add and remove requests and reports
// notified overlapping pairs on a scan.
// ---------------------------------------------------------------------------
module aabb_pairwise_collision_table (
  input  logic                                clk,
  input  logic                                rst,
  // cfg_data: kind_notify_matrix[35:0]
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [aabb_pct_pkg::MATRIX_W-1:0]   cfg_data,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // s_axis_tdata: slot[2:0], rect_x[18:3], rect_y[34:19], rect_w[49:35],
  //   rect_h[64:50], collider_kind[67:65], wants_notice[68], zero[71:69]
  input  logic [aabb_pct_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // s_axis_tuser: mode[1:0]
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // m_axis_tdata: slot_first[2:0], slot_second[5:3], first_notified[6],
  //   second_notified[7], added_ok[8], zero[15:9]
  output logic [aabb_pct_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // m_axis_tuser: event_kind[1:0]
  output logic [1:0]                          m_axis_tuser,
  output logic                                m_axis_tlast
);

  aabb_pct_pkg::cmd_t  cmd;
  aabb_pct_pkg::stat_t stat;

  aabb_pct_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .mode          (s_axis_tuser),
    .stat          (stat),
    .cmd           (cmd)
  );

  aabb_pct_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_data       (s_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

@@ sv/aabb_pct_ctrl.sv @@
// ---------------------------------------------------------------------------
// AABB pair collision table: controller
// Decodes requests and sequences the all-pairs scan through the datapath.
// ---------------------------------------------------------------------------
module aabb_pct_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [1:0]          mode,
  input  aabb_pct_pkg::stat_t stat,
  output aabb_pct_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   accept;

  // Take a request only when idle and the result register can load
  assign s_axis_tready = (state == ST_IDLE) && stat.out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Decode request and step the scan
  always_comb begin
    state_next     = state;
    cmd            = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.add_go     = accept && (mode == aabb_pct_pkg::MODE_ADD);
        cmd.rem_go     = accept && (mode == aabb_pct_pkg::MODE_REMOVE);
        cmd.scan_start = accept && (mode == aabb_pct_pkg::MODE_SCAN);
        if (cmd.scan_start) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.issue = stat.out_free;
        if (stat.out_free && stat.last_pair) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last pair leaves the compare stage
        if (stat.out_free) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.done_go = stat.out_free;
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ sv/aabb_pct_dp.sv @@
// ---------------------------------------------------------------------------
// AABB pair collision table: datapath
// Rectangle memory, occupancy bits, pair counter, overlap compare stage,
// notify matrix and the result register.
// ---------------------------------------------------------------------------
module aabb_pct_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  aabb_pct_pkg::cmd_t                  cmd,
  output aabb_pct_pkg::stat_t                 stat,
  input  logic [aabb_pct_pkg::IN_DATA_W-1:0]  in_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [aabb_pct_pkg::MATRIX_W-1:0]   cfg_data,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [aabb_pct_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [1:0]                          m_axis_tuser,
  output logic                                m_axis_tlast
);

  localparam logic [2:0] KIND_MAX = 3'd5;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [14:0] w;
    logic [14:0] h;
    logic [2:0]  kind;
    logic        listens;
  } entry_t;

  // Strict overlap with edges widened to 17 bits
  function automatic logic overlap(entry_t a, entry_t b);
    logic signed [16:0] ax, ay, bx, by, ar, ab, br, bb;
    ax = signed'({a.x[15], a.x});
    ay = signed'({a.y[15], a.y});
    bx = signed'({b.x[15], b.x});
    by = signed'({b.y[15], b.y});
    ar = ax + signed'({2'b00, a.w});
    ab = ay + signed'({2'b00, a.h});
    br = bx + signed'({2'b00, b.w});
    bb = by + signed'({2'b00, b.h});
    return (br > ax) && (bx < ar) && (bb > ay) && (by < ab);
  endfunction

  // Kinds outside the matrix never take part
  function automatic logic notified(logic [2:0] self, logic [2:0] other, logic listens,
                                    logic [aabb_pct_pkg::MATRIX_W-1:0] mat);
    logic [5:0] idx;
    idx = 6'(self) * 6'd6 + 6'(other);
    if ((self > KIND_MAX) || (other > KIND_MAX) || !listens) begin
      return 1'b0;
    end
    return mat[idx];
  endfunction

  logic [aabb_pct_pkg::MATRIX_W-1:0] matrix;
  logic [aabb_pct_pkg::SLOTS-1:0]    used;
  entry_t                            mem [aabb_pct_pkg::SLOTS];
  entry_t                            new_entry;
  aabb_pct_pkg::slot_t               in_slot;
  aabb_pct_pkg::slot_t               free_slot;
  logic                              any_free;
  aabb_pct_pkg::slot_t               pi, pk;
  logic                              adv;

  // Compare stage
  entry_t              rd_i, rd_k;
  logic                b_vld, b_used;
  aabb_pct_pkg::slot_t b_i, b_k;
  logic                n1, n2, hit;

  // Result register
  logic [1:0]          o_ev;
  aabb_pct_pkg::slot_t o_s1, o_s2;
  logic                o_n1, o_n2, o_ok, o_last;

  assign in_slot   = in_data[2:0];
  assign new_entry = '{x: in_data[18:3], y: in_data[34:19], w: in_data[49:35],
                       h: in_data[64:50], kind: in_data[67:65], listens: in_data[68]};

  // Lowest free slot
  always_comb begin
    free_slot = '0;
    any_free  = 1'b0;
    for (int j = aabb_pct_pkg::SLOTS - 1; j >= 0; j--) begin
      if (!used[j]) begin
        free_slot = aabb_pct_pkg::slot_t'(j);
        any_free  = 1'b1;
      end
    end
  end

  // Result register loads when empty or being taken
  assign adv            = !m_axis_tvalid || m_axis_tready;
  assign stat.out_free  = adv;
  assign stat.last_pair = (pi == aabb_pct_pkg::slot_t'(aabb_pct_pkg::SLOTS - 2)) &&
                          (pk == aabb_pct_pkg::LAST_SLOT);
  assign cfg_ready      = 1'b1;

  // Pair test on the registered table reads
  assign hit = b_vld && b_used && overlap(rd_i, rd_k);
  assign n1  = notified(rd_i.kind, rd_k.kind, rd_i.listens, matrix);
  assign n2  = notified(rd_k.kind, rd_i.kind, rd_k.listens, matrix);

  // Table memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.add_go && any_free) begin
      mem[free_slot] <= new_entry;
    end
    if (adv) begin
      rd_i <= mem[pi];
      rd_k <= mem[pk];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix        <= aabb_pct_pkg::MATRIX_RESET;
      used          <= '0;
      pi            <= '0;
      pk            <= '0;
      b_vld         <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        matrix <= cfg_data;
      end
      if (cmd.add_go && any_free) begin
        used[free_slot] <= 1'b1;
      end
      if (cmd.rem_go) begin
        used[in_slot] <= 1'b0;
      end
      // Advance the pair counter in ascending (i, k) order
      if (cmd.scan_start) begin
        pi <= '0;
        pk <= aabb_pct_pkg::slot_t'(1);
      end else if (cmd.issue) begin
        if (pk == aabb_pct_pkg::LAST_SLOT) begin
          pi <= pi + aabb_pct_pkg::slot_t'(1);
          pk <= pi + aabb_pct_pkg::slot_t'(2);
        end else begin
          pk <= pk + aabb_pct_pkg::slot_t'(1);
        end
      end
      if (adv) begin
        b_vld         <= cmd.issue;
        m_axis_tvalid <= cmd.add_go || cmd.rem_go || cmd.done_go || (hit && (n1 || n2));
      end
    end
  end

  // Compare stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      b_i    <= pi;
      b_k    <= pk;
      b_used <= used[pi] && used[pk];
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (adv) begin
      o_s2 <= '0;
      o_n1 <= 1'b0;
      o_n2 <= 1'b0;
      o_ok <= 1'b0;
      priority if (cmd.add_go) begin
        o_ev   <= aabb_pct_pkg::EV_ADD;
        o_s1   <= any_free ? free_slot : '0;
        o_ok   <= any_free;
        o_last <= 1'b1;
      end else if (cmd.rem_go) begin
        o_ev   <= aabb_pct_pkg::EV_REMOVE;
        o_s1   <= in_slot;
        o_last <= 1'b1;
      end else if (cmd.done_go) begin
        o_ev   <= aabb_pct_pkg::EV_DONE;
        o_s1   <= '0;
        o_last <= 1'b1;
      end else begin
        o_ev   <= aabb_pct_pkg::EV_PAIR;
        o_s1   <= b_i;
        o_s2   <= b_k;
        o_n1   <= n1;
        o_n2   <= n2;
        o_last <= 1'b0;
      end
    end
  end

  assign m_axis_tdata = {7'b0, o_ok, o_n2, o_n1, o_s2, o_s1};
  assign m_axis_tuser = o_ev;
  assign m_axis_tlast = o_last;

endmodule

@@ tb/sv/aabb_pairwise_collision_table_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// AABB pair collision table testbench
// Streams add, remove and scan requests into the table and checks every
// result against a cycle-free model of the rectangle table, with the notify
// matrix rewritten between phases and random gaps on both stream sides.
// ---------------------------------------------------------------------------
module aabb_pairwise_collision_table_tb;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int MAX_PAIRS = 28;
  localparam int DRAIN_CYCLES = 64;
  localparam int LIMIT_CYCLES = 500000;
  localparam int RANDOM_PER_PHASE = 42;
  localparam int PHASES = 8;

  typedef logic [aabb_pct_pkg::MATRIX_W-1:0] matrix_t;

  typedef struct packed {
    logic [1:0]          mode;
    aabb_pct_pkg::slot_t slot;
    logic signed [15:0]  x;
    logic signed [15:0]  y;
    logic [14:0]         w;
    logic [14:0]         h;
    logic [2:0]          kind;
    logic                notice;
  } rect_req_t;

  typedef struct packed {
    logic [1:0]          ev;
    aabb_pct_pkg::slot_t slot_lo;
    aabb_pct_pkg::slot_t slot_hi;
    logic                lo_told;
    logic                hi_told;
    logic                ok;
    logic                last;
  } table_event_t;

  typedef enum {STEP_REQ, STEP_CFG, STEP_DRAIN, STEP_PHASE} step_kind_t;

  typedef struct {
    step_kind_t op;
    rect_req_t  req;
    matrix_t    matrix;
    int         idle_pct;
    int         stall_pct;
  } stim_step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [aabb_pct_pkg::MATRIX_W-1:0]   cfg_data = '0;
  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  logic [aabb_pct_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]                          s_axis_tuser = '0;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  logic [aabb_pct_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]                          m_axis_tuser;
  logic                                m_axis_tlast;

  // Shadow of the table and the notify register
  logic [aabb_pct_pkg::MATRIX_W-1:0] notify_matrix = aabb_pct_pkg::MATRIX_RESET;
  bit                  slot_busy [aabb_pct_pkg::SLOTS];
  int                  rect_left [aabb_pct_pkg::SLOTS];
  int                  rect_top [aabb_pct_pkg::SLOTS];
  int                  rect_wide [aabb_pct_pkg::SLOTS];
  int                  rect_tall [aabb_pct_pkg::SLOTS];
  logic [2:0]          rect_kind [aabb_pct_pkg::SLOTS];
  bit                  rect_listens [aabb_pct_pkg::SLOTS];

  table_event_t events_due[$];
  stim_step_t   pending[$];
  rect_req_t    req_cur;

  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  int error_count = 0;
  int cycle_count = 0;

  aabb_pairwise_collision_table i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (error_count < 100) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
    error_count++;
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    end
  endtask

  function automatic bit kind_notified(input logic [2:0] self, input logic [2:0] other,
                                       input bit listens);
    logic [5:0] idx;
    idx = 6'(self) * 6'd6 + 6'(other);
    // Kinds past the last matrix row never take part
    if (self > 3'd5 || other > 3'd5 || !listens) begin
      return 1'b0;
    end
    return notify_matrix[idx];
  endfunction

  // Strict overlap on widened edges
  function automatic bit rects_overlap(input int a, input int b);
    return (rect_left[b] + rect_wide[b] > rect_left[a]) &&
           (rect_left[b] < rect_left[a] + rect_wide[a]) &&
           (rect_top[b] + rect_tall[b] > rect_top[a]) &&
           (rect_top[b] < rect_top[a] + rect_tall[a]);
  endfunction

  // Advance the table shadow by one request and queue its results
  task automatic apply_request(input rect_req_t r);
    table_event_t res;
    bit placed;
    bit lo_told;
    bit hi_told;
    int pairs;
    res = '0;
    placed = 1'b0;
    pairs = 0;
    case (r.mode)
      aabb_pct_pkg::MODE_ADD: begin
        res.ev = aabb_pct_pkg::EV_ADD;
        res.last = 1'b1;
        for (int i = 0; i < aabb_pct_pkg::SLOTS; i++) begin
          if (!placed && !slot_busy[i]) begin
            rect_left[i] = int'($signed(r.x));
            rect_top[i] = int'($signed(r.y));
            rect_wide[i] = int'(r.w);
            rect_tall[i] = int'(r.h);
            rect_kind[i] = r.kind;
            rect_listens[i] = r.notice;
            slot_busy[i] = 1'b1;
            res.slot_lo = aabb_pct_pkg::slot_t'(i);
            res.ok = 1'b1;
            placed = 1'b1;
          end
        end
        events_due.push_back(res);
      end
      aabb_pct_pkg::MODE_REMOVE: begin
        slot_busy[r.slot] = 1'b0;
        res.ev = aabb_pct_pkg::EV_REMOVE;
        res.slot_lo = r.slot;
        res.last = 1'b1;
        events_due.push_back(res);
      end
      aabb_pct_pkg::MODE_SCAN: begin
        for (int i = 0; i < aabb_pct_pkg::SLOTS; i++) begin
          for (int k = i + 1; k < aabb_pct_pkg::SLOTS; k++) begin
            if (slot_busy[i] && slot_busy[k] && rects_overlap(i, k)) begin
              lo_told = kind_notified(rect_kind[i], rect_kind[k], rect_listens[i]);
              hi_told = kind_notified(rect_kind[k], rect_kind[i], rect_listens[k]);
              if ((lo_told || hi_told) && pairs < MAX_PAIRS) begin
                res = '0;
                res.ev = aabb_pct_pkg::EV_PAIR;
                res.slot_lo = aabb_pct_pkg::slot_t'(i);
                res.slot_hi = aabb_pct_pkg::slot_t'(k);
                res.lo_told = lo_told;
                res.hi_told = hi_told;
                events_due.push_back(res);
                pairs++;
              end
            end
          end
        end
        res = '0;
        res.ev = aabb_pct_pkg::EV_DONE;
        res.last = 1'b1;
        events_due.push_back(res);
      end
      default: begin
      end
    endcase
  endtask

  function automatic rect_req_t make_req(input logic [1:0] mode, input int slot,
                                         input int x, input int y, input int w,
                                         input int h, input int kind, input bit notice);
    rect_req_t r;
    r.mode = mode;
    r.slot = aabb_pct_pkg::slot_t'(slot);
    r.x = 16'(x);
    r.y = 16'(y);
    r.w = 15'(w);
    r.h = 15'(h);
    r.kind = 3'(kind);
    r.notice = notice;
    return r;
  endfunction

  function automatic int pick_edge();
    case ($urandom_range(3))
      0: return -32768;
      1: return 32767;
      2: return 30000;
      default: return -30000;
    endcase
  endfunction

  function automatic int pick_span();
    case ($urandom_range(2))
      0: return 0;
      1: return 32767;
      default: return 30000;
    endcase
  endfunction

  function automatic rect_req_t random_request();
    rect_req_t r;
    int pick;
    int shape;
    pick = $urandom_range(99);
    shape = $urandom_range(9);
    if (pick < 45) begin
      r.mode = aabb_pct_pkg::MODE_ADD;
    end else if (pick < 72) begin
      r.mode = aabb_pct_pkg::MODE_REMOVE;
    end else if (pick < 95) begin
      r.mode = aabb_pct_pkg::MODE_SCAN;
    end else begin
      r.mode = MODE_UNUSED;
    end
    r.slot = aabb_pct_pkg::slot_t'($urandom_range(aabb_pct_pkg::SLOTS - 1));
    // Mostly a crowded arena, some full-range and some edge-of-range boxes
    if (shape < 7) begin
      r.x = 16'(int'($urandom_range(80)) - 40);
      r.y = 16'(int'($urandom_range(80)) - 40);
      r.w = ($urandom_range(9) == 0) ? 15'd0 : 15'($urandom_range(60));
      r.h = ($urandom_range(9) == 0) ? 15'd0 : 15'($urandom_range(60));
    end else if (shape < 9) begin
      r.x = 16'($urandom);
      r.y = 16'($urandom);
      r.w = 15'($urandom);
      r.h = 15'($urandom);
    end else begin
      r.x = 16'(pick_edge());
      r.y = 16'(pick_edge());
      r.w = 15'(pick_span());
      r.h = 15'(pick_span());
    end
    r.kind = ($urandom_range(99) < 88) ? 3'($urandom_range(5)) : 3'($urandom_range(7, 6));
    r.notice = ($urandom_range(99) < 75);
    return r;
  endfunction

  task automatic queue_request(input rect_req_t r);
    stim_step_t s;
    s.op = STEP_REQ;
    s.req = r;
    s.matrix = '0;
    s.idle_pct = 0;
    s.stall_pct = 0;
    pending.push_back(s);
  endtask

  task automatic queue_control(input step_kind_t op, input matrix_t matrix,
                               input int idle, input int stall);
    stim_step_t s;
    s.op = op;
    s.req = '0;
    s.matrix = matrix;
    s.idle_pct = idle;
    s.stall_pct = stall;
    pending.push_back(s);
  endtask

  // Driver: present pending requests and register writes
  always @(posedge clk) begin
    stim_step_t head;
    bit req_hold;
    bit cfg_hold;
    bit next_s_valid;
    bit next_cfg_valid;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
      quiet_cycles = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_request(req_cur);
      end
      if (cfg_valid && cfg_ready) begin
        notify_matrix = cfg_data;
      end
      if (events_due.size() == 0 && !s_axis_tvalid) begin
        quiet_cycles++;
      end else begin
        quiet_cycles = 0;
      end
      req_hold = s_axis_tvalid && !s_axis_tready;
      cfg_hold = cfg_valid && !cfg_ready;
      next_s_valid = req_hold;
      next_cfg_valid = cfg_hold;
      if (!req_hold && !cfg_hold && pending.size() != 0) begin
        head = pending[0];
        case (head.op)
          STEP_PHASE: begin
            idle_pct = head.idle_pct;
            stall_pct <= head.stall_pct;
            void'(pending.pop_front());
          end
          STEP_DRAIN: begin
            if (quiet_cycles >= DRAIN_CYCLES) begin
              void'(pending.pop_front());
            end
          end
          STEP_CFG: begin
            // Write only once the table has gone quiet
            if (quiet_cycles >= DRAIN_CYCLES) begin
              cfg_data <= head.matrix;
              next_cfg_valid = 1'b1;
              void'(pending.pop_front());
            end
          end
          default: begin
            if ($urandom_range(99) >= idle_pct) begin
              req_cur = head.req;
              s_axis_tdata <= {3'b000, head.req.notice, head.req.kind, head.req.h,
                               head.req.w, head.req.y, head.req.x, head.req.slot};
              s_axis_tuser <= head.req.mode;
              next_s_valid = 1'b1;
              void'(pending.pop_front());
            end
          end
        endcase
      end
      s_axis_tvalid <= next_s_valid;
      cfg_valid <= next_cfg_valid;
    end
  end

  // Monitor: compare each result with the oldest expected one
  always @(posedge clk) begin
    table_event_t got;
    table_event_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.ev = m_axis_tuser;
        got.slot_lo = m_axis_tdata[2:0];
        got.slot_hi = m_axis_tdata[5:3];
        got.lo_told = m_axis_tdata[6];
        got.hi_told = m_axis_tdata[7];
        got.ok = m_axis_tdata[8];
        got.last = m_axis_tlast;
        if (events_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d", got.ev));
        end else begin
          want = events_due.pop_front();
          compare_field("event_kind", int'(got.ev), int'(want.ev));
          compare_field("slot_first", int'(got.slot_lo), int'(want.slot_lo));
          compare_field("slot_second", int'(got.slot_hi), int'(want.slot_hi));
          compare_field("first_notified", int'(got.lo_told), int'(want.lo_told));
          compare_field("second_notified", int'(got.hi_told), int'(want.hi_told));
          compare_field("added_ok", int'(got.ok), int'(want.ok));
          compare_field("last", int'(got.last), int'(want.last));
        end
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rect_req_t r;
    matrix_t matrix;

    // Directed: empty scan, free remove, range edges, touching and empty boxes
    queue_control(STEP_PHASE, '0, 0, 0);
    queue_request(make_req(aabb_pct_pkg::MODE_SCAN, 0, 0, 0, 0, 0, 0, 0));
    queue_request(make_req(aabb_pct_pkg::MODE_REMOVE, 7, 0, 0, 0, 0, 0, 0));
    queue_request(make_req(aabb_pct_pkg::MODE_ADD, 0, -32768, -32768, 32767, 32767, 2, 1));
    queue_request(make_req(aabb_pct_pkg::MODE_ADD, 0, 32767, 32767, 32767, 32767, 3, 1));
    queue_request(make_req(aabb_pct_pkg::MODE_ADD, 0, 0, 0, 0, 0, 4, 1));
    queue_request(make_req(aabb_pct_pkg::MODE_ADD, 0, -10, -10, 20, 20, 4, 1));
    queue_request(make_req(aabb_pct_pkg::MODE_ADD, 0, 10, -10, 5, 5, 1, 1));
    queue_request(make_req(aabb_pct_pkg::MODE_ADD, 0, -5, -5, 10, 10, 5, 0));
    queue_request(make_req(aabb_pct_pkg::MODE_ADD, 0, 0, 0, 3, 3, 6, 1));
    queue_request(make_req(aabb_pct_pkg::MODE_ADD, 0, 0, 0, 3, 3, 7, 1));
    queue_request(make_req(aabb_pct_pkg::MODE_ADD, 0, 1, 1, 1, 1, 2, 1));
    queue_request(make_req(aabb_pct_pkg::MODE_SCAN, 0, 0, 0, 0, 0, 0, 0));
    queue_request(make_req(MODE_UNUSED, 5, -1, -1, 32767, 32767, 7, 1));
    queue_request(make_req(aabb_pct_pkg::MODE_REMOVE, 2, 0, 0, 0, 0, 0, 0));
    queue_request(make_req(aabb_pct_pkg::MODE_REMOVE, 2, 0, 0, 0, 0, 0, 0));
    queue_request(make_req(aabb_pct_pkg::MODE_ADD, 0, -1, -1, 2, 2, 0, 1));
    queue_request(make_req(aabb_pct_pkg::MODE_SCAN, 0, 0, 0, 0, 0, 0, 0));
    queue_request(make_req(aabb_pct_pkg::MODE_REMOVE, 0, 0, 0, 0, 0, 0, 0));
    queue_request(make_req(aabb_pct_pkg::MODE_SCAN, 0, 0, 0, 0, 0, 0, 0));

    // Random phases, each with its own gap pattern and notify matrix
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: queue_control(STEP_PHASE, '0, 0, 0);
        1: queue_control(STEP_PHASE, '0, 45, 0);
        2: queue_control(STEP_PHASE, '0, 0, 45);
        default: queue_control(STEP_PHASE, '0, 16, 16);
      endcase
      case (p)
        0: matrix = aabb_pct_pkg::MATRIX_RESET;
        1, 5: matrix = '1;
        2: matrix = '0;
        4: matrix = aabb_pct_pkg::MATRIX_RESET;
        default: matrix = matrix_t'({$urandom, $urandom});
      endcase
      if (p != 0) begin
        queue_control(STEP_CFG, matrix, 0, 0);
      end
      // Fill the table with boxes sharing a common area for a full pair scan
      if (matrix == '1) begin
        for (int s = 0; s < aabb_pct_pkg::SLOTS; s++) begin
          queue_request(make_req(aabb_pct_pkg::MODE_REMOVE, s, 0, 0, 0, 0, 0, 0));
        end
        for (int s = 0; s < aabb_pct_pkg::SLOTS; s++) begin
          queue_request(make_req(aabb_pct_pkg::MODE_ADD, 0, int'($urandom_range(10)) - 10,
                                 int'($urandom_range(10)) - 10,
                                 int'($urandom_range(40, 20)), int'($urandom_range(40, 20)),
                                 int'($urandom_range(5)), 1'b1));
        end
        queue_request(make_req(aabb_pct_pkg::MODE_SCAN, 0, 0, 0, 0, 0, 0, 0));
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        r = random_request();
        queue_request(r);
        // Hold off until the table has answered everything
        if (p == 3 && n == RANDOM_PER_PHASE / 2) begin
          queue_control(STEP_DRAIN, '0, 0, 0);
        end
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || s_axis_tvalid || cfg_valid || events_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (events_due.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", events_due.size()));
    end
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ aabb_pairwise_collision_table.f @@
sv/aabb_pct_pkg.sv
sv/aabb_pct_ctrl.sv
sv/aabb_pct_dp.sv
sv/aabb_pairwise_collision_table.sv
tb/sv/aabb_pairwise_collision_table_tb.sv
